[rtl/hrfpl_pkg.sv]
// Shared types, constants and helpers of the hex record flash page loader.
`default_nettype none

package hrfpl_pkg;

  localparam int unsigned PAGE_BYTES_DEF     = 512;
  localparam int unsigned MAX_DATA_BYTES_DEF = 16;
  localparam int unsigned QUEUE_DEPTH        = 2;
  localparam int unsigned RESULT_CAP         = 16;

  localparam logic [15:0] LOWER_RESET = 16'h4000;
  localparam logic [15:0] UPPER_RESET = 16'h7FFF;
  localparam logic [15:0] NO_ADDRESS  = 16'hFFFF;
  localparam logic [7:0]  CHAR_COLON  = 8'h3A;
  localparam logic [7:0]  BYTE_PAD    = 8'hFF;
  localparam logic [7:0]  KIND_DATA   = 8'h00;
  localparam logic [7:0]  KIND_EOF    = 8'h01;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER = 1'b1;

  localparam int unsigned OUT_DATA_W = 48;

  typedef enum logic [2:0] {
    CMD_LOAD     = 3'd0,
    CMD_COMMIT   = 3'd1,
    CMD_FINISHED = 3'd2,
    CMD_ERROR    = 3'd3,
    CMD_IGNORED  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_CHECKSUM = 3'd1,
    ERR_RANGE    = 3'd2,
    ERR_NONHEX   = 3'd3,
    ERR_TOO_LONG = 3'd4
  } err_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_COUNT,
    PH_ADDR_HI,
    PH_ADDR_LO,
    PH_KIND,
    PH_DATA,
    PH_SUM
  } phase_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PAIR,
    BK_LOAD,
    BK_EOF,
    BK_FINISH,
    BK_SINGLE
  } back_state_e;

  typedef enum logic [1:0] {
    JOB_DATA,
    JOB_EOF,
    JOB_IGNORE,
    JOB_ERROR
  } job_kind_e;

  // One finished record, or one parse error, handed to the back end.
  typedef struct packed {
    job_kind_e   kind;
    err_e        err;
    logic [7:0]  count;
    logic [15:0] address;
  } job_t;

  // Byte write into the record data buffer.
  typedef struct packed {
    logic       en;
    logic       hi_lane;
    logic [7:0] data;
  } buf_wr_t;

  // Returns {invalid, nibble} for one character.
  function automatic logic [4:0] hex_decode(logic [7:0] c);
    logic [4:0] r;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b0, c[3:0]};
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r = {1'b0, 4'(c[3:0] + 4'd9)};
    end else begin
      r = 5'h10;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/hex_record_flash_page_loader.sv]
// Top level: Intel HEX text in, flash page load and commit commands out.
//
// The input stream carries one character per transfer in s_axis_tdata. The
// output stream carries one command per transfer: m_axis_tuser is the command
// and m_axis_tlast marks the final result caused by one character.
// Limits for the page range check are written through the cfg port, by the
// user only while the block is idle; the block itself does not enforce this.
// Index 0 is the lower limit, index 1 the upper limit. The parser queues a
// job per finished record other than an empty data record, and one per parse
// error; the executor takes a job, then handles each byte pair as a buffer
// read, with any page commit or range error in the same state, then the load.
// An end-of-file job yields a commit when a page is open and then finished,
// or a range error; any other job yields a single result. While the executor
// is busy or a job waits in the queue, data digits of the next record wait;
// other characters flow at one per cycle until the two-entry job queue is
// full. When the receiver stalls, the output register holds its transfer,
// the executor waits and the queue fills before input stalls. Reset restores
// the limits to 0x4000 and 0x7FFF, empties queue and output and puts the
// parser back to waiting for a colon. After an error the block drops all
// input until the next reset.
`default_nettype none

module hex_record_flash_page_loader #(
  parameter int unsigned PAGE_BYTES     = hrfpl_pkg::PAGE_BYTES_DEF,
  parameter int unsigned MAX_DATA_BYTES = hrfpl_pkg::MAX_DATA_BYTES_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire  [7:0]                       s_axis_tdata,  // [7:0] text_char
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // [8:0] page_offset, [24:9] flash_word, [40:25] page_address,
  // [43:41] error_code, [47:44] zero
  output logic [hrfpl_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic [2:0]                       m_axis_tuser,  // [2:0] command
  output logic                             m_axis_tlast,  // last_of_run
  input  wire                              cfg_we_i,
  input  wire  [hrfpl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire  [15:0]                      cfg_data_i
);
  import hrfpl_pkg::*;

  localparam int unsigned WORDS  = (MAX_DATA_BYTES + 1) / 2;
  localparam int unsigned WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic [15:0]       lower_q, upper_q;
  logic              push;
  job_t              push_job;
  job_t              head;
  logic              q_empty, q_full, q_pop;
  logic              back_busy;
  buf_wr_t           buf_wr;
  logic [WIDX_W-1:0] buf_widx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= LOWER_RESET;
      upper_q <= UPPER_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LOWER: lower_q <= cfg_data_i;
        REG_UPPER: upper_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  hrfpl_front #(
    .MAX_DATA_BYTES(MAX_DATA_BYTES),
    .WIDX_W        (WIDX_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tdata_i  (s_axis_tdata),
    .s_tready_o (s_axis_tready),
    .lock_i     (back_busy || !q_empty),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_job_o (push_job),
    .buf_wr_o   (buf_wr),
    .buf_widx_o (buf_widx)
  );

  hrfpl_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (q_pop),
    .head_o     (head),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  hrfpl_back #(
    .PAGE_BYTES    (PAGE_BYTES),
    .MAX_DATA_BYTES(MAX_DATA_BYTES),
    .WIDX_W        (WIDX_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_head_i   (head),
    .q_pop_o    (q_pop),
    .busy_o     (back_busy),
    .buf_wr_i   (buf_wr),
    .buf_widx_i (buf_widx),
    .lower_i    (lower_q),
    .upper_i    (upper_q),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tuser_o  (m_axis_tuser),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

[rtl/hrfpl_front.sv]
// Character parser: decodes records, fills the data buffer and queues record jobs.
`default_nettype none

module hrfpl_front #(
  parameter int unsigned MAX_DATA_BYTES = hrfpl_pkg::MAX_DATA_BYTES_DEF,
  parameter int unsigned WIDX_W         = 3
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_tvalid_i,
  input  wire  [7:0]           s_tdata_i,
  output logic                 s_tready_o,
  input  wire                  lock_i,
  input  wire                  q_full_i,
  output logic                 push_o,
  output hrfpl_pkg::job_t      push_job_o,
  output hrfpl_pkg::buf_wr_t   buf_wr_o,
  output logic [WIDX_W-1:0]    buf_widx_o
);
  import hrfpl_pkg::*;

  localparam int unsigned BIDX_W = $clog2(MAX_DATA_BYTES + 1);

  phase_e              phase_q, phase_d;
  logic [4:0]          nib_q, nib_d;
  logic [BIDX_W-1:0]   idx_q, idx_d;
  logic [7:0]          sum_q, sum_d;
  logic [7:0]          count_q, count_d;
  logic [15:0]         addr_q, addr_d;
  logic [7:0]          kind_q, kind_d;
  logic                halted_q, halted_d;

  logic                accept;
  logic [4:0]          hexd;
  logic [7:0]          byte_val;
  logic [7:0]          sum_next;
  logic                too_long;
  logic                data_last;

  assign s_tready_o = halted_q || (!q_full_i && !((phase_q == PH_DATA) && lock_i));
  assign accept     = s_tvalid_i && s_tready_o;
  assign hexd       = hex_decode(s_tdata_i);
  assign byte_val   = {nib_q[3:0], hexd[3:0]};
  assign sum_next   = sum_q + byte_val;
  assign too_long   = byte_val > 8'(MAX_DATA_BYTES);
  assign data_last  = (8'(idx_q) + 8'd1) >= count_q;
  assign buf_widx_o = idx_q[WIDX_W:1];

  // Next phase of the record parser.
  always_comb begin
    phase_d = phase_q;
    if (accept && !halted_q) begin
      if (phase_q == PH_IDLE) begin
        if (s_tdata_i == CHAR_COLON) begin
          phase_d = PH_COUNT;
        end
      end else if (hexd[4]) begin
        phase_d = PH_IDLE;
      end else if (nib_q[4]) begin
        case (phase_q)
          PH_COUNT:   phase_d = too_long ? PH_IDLE : PH_ADDR_HI;
          PH_ADDR_HI: phase_d = PH_ADDR_LO;
          PH_ADDR_LO: phase_d = PH_KIND;
          PH_KIND:    phase_d = (count_q != 8'd0) ? PH_DATA : PH_SUM;
          PH_DATA:    phase_d = data_last ? PH_SUM : PH_DATA;
          default:    phase_d = PH_IDLE;
        endcase
      end
    end
  end

  // Datapath registers, buffer writes and job pushes.
  always_comb begin
    nib_d      = nib_q;
    idx_d      = idx_q;
    sum_d      = sum_q;
    count_d    = count_q;
    addr_d     = addr_q;
    kind_d     = kind_q;
    halted_d   = halted_q;
    push_o     = 1'b0;
    push_job_o = '0;
    buf_wr_o   = '0;
    push_job_o.count   = count_q;
    push_job_o.address = addr_q;
    if (accept && !halted_q) begin
      if (phase_q == PH_IDLE) begin
        if (s_tdata_i == CHAR_COLON) begin
          sum_d = 8'd0;
          nib_d = 5'd0;
          idx_d = '0;
        end
      end else if (hexd[4]) begin
        push_o         = 1'b1;
        push_job_o.kind = JOB_ERROR;
        push_job_o.err  = ERR_NONHEX;
        halted_d       = 1'b1;
      end else if (!nib_q[4]) begin
        nib_d = {1'b1, hexd[3:0]};
      end else begin
        nib_d = 5'd0;
        sum_d = sum_next;
        case (phase_q)
          PH_COUNT: begin
            count_d = byte_val;
            if (too_long) begin
              push_o          = 1'b1;
              push_job_o.kind = JOB_ERROR;
              push_job_o.err  = ERR_TOO_LONG;
              halted_d        = 1'b1;
            end
          end
          PH_ADDR_HI: addr_d[15:8] = byte_val;
          PH_ADDR_LO: addr_d[7:0]  = byte_val;
          PH_KIND: begin
            kind_d = byte_val;
            idx_d  = '0;
          end
          PH_DATA: begin
            buf_wr_o.en      = 1'b1;
            buf_wr_o.hi_lane = idx_q[0];
            buf_wr_o.data    = byte_val;
            idx_d            = idx_q + 1'b1;
          end
          PH_SUM: begin
            if (sum_next != 8'd0) begin
              push_o          = 1'b1;
              push_job_o.kind = JOB_ERROR;
              push_job_o.err  = ERR_CHECKSUM;
              halted_d        = 1'b1;
            end else if (kind_q == KIND_DATA) begin
              // An empty data record yields nothing.
              push_o          = count_q != 8'd0;
              push_job_o.kind = JOB_DATA;
            end else if (kind_q == KIND_EOF) begin
              push_o          = 1'b1;
              push_job_o.kind = JOB_EOF;
            end else begin
              push_o          = 1'b1;
              push_job_o.kind = JOB_IGNORE;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      nib_q    <= 5'd0;
      idx_q    <= '0;
      sum_q    <= 8'd0;
      count_q  <= 8'd0;
      addr_q   <= 16'd0;
      kind_q   <= 8'd0;
      halted_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      nib_q    <= nib_d;
      idx_q    <= idx_d;
      sum_q    <= sum_d;
      count_q  <= count_d;
      addr_q   <= addr_d;
      kind_q   <= kind_d;
      halted_q <= halted_d;
    end
  end

endmodule

`default_nettype wire

[rtl/hrfpl_queue.sv]
// Short job queue between the parser and the page executor.
`default_nettype none

module hrfpl_queue (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  hrfpl_pkg::job_t  push_job_i,
  input  wire              pop_i,
  output hrfpl_pkg::job_t  head_o,
  output logic             empty_o,
  output logic             full_o
);
  import hrfpl_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  job_t              entries_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]    cnt_q, cnt_d;

  assign head_o  = entries_q[rd_ptr_q];
  assign empty_o = cnt_q == '0;
  assign full_o  = cnt_q == (PTR_W + 1)'(QUEUE_DEPTH);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[rtl/hrfpl_back.sv]
// Page executor: turns record jobs into load, commit, finished and error results.
`default_nettype none

module hrfpl_back #(
  parameter int unsigned PAGE_BYTES     = hrfpl_pkg::PAGE_BYTES_DEF,
  parameter int unsigned MAX_DATA_BYTES = hrfpl_pkg::MAX_DATA_BYTES_DEF,
  parameter int unsigned WIDX_W         = 3
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              q_empty_i,
  input  hrfpl_pkg::job_t                  q_head_i,
  output logic                             q_pop_o,
  output logic                             busy_o,
  input  hrfpl_pkg::buf_wr_t               buf_wr_i,
  input  wire  [WIDX_W-1:0]                buf_widx_i,
  input  wire  [15:0]                      lower_i,
  input  wire  [15:0]                      upper_i,
  output logic                             m_tvalid_o,
  input  wire                              m_tready_i,
  output logic [2:0]                       m_tuser_o,
  output logic [hrfpl_pkg::OUT_DATA_W-1:0] m_tdata_o,
  output logic                             m_tlast_o
);
  import hrfpl_pkg::*;

  // Pages are a power of two bytes long.
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam logic [15:0] PAGE_MASK  = 16'(PAGE_BYTES - 1);
  localparam int unsigned WORDS      = (MAX_DATA_BYTES + 1) / 2;
  localparam int unsigned BIDX_W     = $clog2(MAX_DATA_BYTES + 1);
  localparam int unsigned RC_W       = $clog2(RESULT_CAP + 1);

  // Record data, one entry per byte pair.
  logic [7:0] lo_mem [WORDS];
  logic [7:0] hi_mem [WORDS];
  logic [7:0] lo_rd_q, hi_rd_q;

  back_state_e         state_q, state_d;
  job_t                job_q, job_d;
  logic [15:0]         addr_q, addr_d;
  logic [BIDX_W-1:0]   pos_q, pos_d;
  logic [15:0]         prior_q, prior_d;
  logic                empty_q, empty_d;
  logic                halted_q, halted_d;
  logic [RC_W-1:0]     rc_q, rc_d;
  logic                out_valid_q, out_valid_d;
  cmd_e                out_cmd_q;
  logic [8:0]          out_off_q;
  logic [15:0]         out_word_q;
  logic [15:0]         out_page_q;
  err_e                out_err_q;
  logic                out_last_q;

  logic                can_emit;
  logic                page_change;
  logic                out_of_range;
  logic                last_pair;
  logic [15:0]         page_base;
  logic                e_req, e_load;
  cmd_e                e_cmd;
  logic [8:0]          e_off;
  logic [15:0]         e_word;
  logic [15:0]         e_page;
  err_e                e_err;
  logic                e_last;

  assign can_emit     = !out_valid_q || m_tready_i;
  assign page_change  = (prior_q >> PAGE_SHIFT) != (addr_q >> PAGE_SHIFT);
  assign out_of_range = (prior_q < lower_i) || (prior_q > upper_i);
  assign last_pair    = (8'(pos_q) + 8'd2) >= job_q.count;
  assign page_base    = prior_q & ~PAGE_MASK;
  assign busy_o       = state_q != BK_IDLE;

  always_ff @(posedge clk_i) begin
    if (buf_wr_i.en) begin
      if (buf_wr_i.hi_lane) begin
        hi_mem[buf_widx_i] <= buf_wr_i.data;
      end else begin
        // The pad byte stands until an odd byte replaces it.
        lo_mem[buf_widx_i] <= buf_wr_i.data;
        hi_mem[buf_widx_i] <= BYTE_PAD;
      end
    end
    lo_rd_q <= lo_mem[pos_q[WIDX_W:1]];
    hi_rd_q <= hi_mem[pos_q[WIDX_W:1]];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i && !halted_q) begin
          case (q_head_i.kind)
            JOB_DATA: state_d = BK_PAIR;
            JOB_EOF:  state_d = BK_EOF;
            default:  state_d = BK_SINGLE;
          endcase
        end
      end
      BK_PAIR: begin
        if (!empty_q && page_change) begin
          if (can_emit) begin
            state_d = out_of_range ? BK_IDLE : BK_LOAD;
          end
        end else begin
          state_d = BK_LOAD;
        end
      end
      BK_LOAD: begin
        if (can_emit) begin
          state_d = last_pair ? BK_IDLE : BK_PAIR;
        end
      end
      BK_EOF: begin
        if (empty_q) begin
          state_d = BK_FINISH;
        end else if (can_emit) begin
          state_d = out_of_range ? BK_IDLE : BK_FINISH;
        end
      end
      BK_FINISH, BK_SINGLE: begin
        if (can_emit) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Results and page tracking.
  always_comb begin
    q_pop_o  = 1'b0;
    e_req    = 1'b0;
    e_cmd    = CMD_LOAD;
    e_off    = 9'd0;
    e_word   = 16'd0;
    e_page   = 16'd0;
    e_err    = ERR_NONE;
    e_last   = 1'b0;
    job_d    = job_q;
    addr_d   = addr_q;
    pos_d    = pos_q;
    prior_d  = prior_q;
    empty_d  = empty_q;
    halted_d = halted_q;
    rc_d     = rc_q;
    case (state_q)
      BK_IDLE: begin
        // After an error every queued job is dropped.
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          job_d   = q_head_i;
          addr_d  = q_head_i.address;
          pos_d   = '0;
          rc_d    = '0;
        end
      end
      BK_PAIR, BK_EOF: begin
        if (!empty_q && (page_change || (state_q == BK_EOF)) && can_emit) begin
          e_req = 1'b1;
          if (out_of_range) begin
            e_cmd    = CMD_ERROR;
            e_err    = ERR_RANGE;
            e_last   = 1'b1;
            halted_d = 1'b1;
          end else begin
            e_cmd  = CMD_COMMIT;
            e_page = page_base;
          end
        end
      end
      BK_LOAD: begin
        if (can_emit) begin
          e_req   = 1'b1;
          e_cmd   = CMD_LOAD;
          e_off   = 9'(addr_q & PAGE_MASK);
          e_word  = {hi_rd_q, lo_rd_q};
          e_last  = last_pair;
          empty_d = 1'b0;
          prior_d = addr_q;
          addr_d  = addr_q + 16'd2;
          if (!last_pair) begin
            pos_d = pos_q + BIDX_W'(2);
          end
        end
      end
      BK_FINISH: begin
        if (can_emit) begin
          e_req   = 1'b1;
          e_cmd   = CMD_FINISHED;
          e_last  = 1'b1;
          empty_d = 1'b1;
          prior_d = NO_ADDRESS;
        end
      end
      BK_SINGLE: begin
        if (can_emit) begin
          e_req  = 1'b1;
          e_last = 1'b1;
          if (job_q.kind == JOB_ERROR) begin
            e_cmd    = CMD_ERROR;
            e_err    = job_q.err;
            halted_d = 1'b1;
          end else begin
            e_cmd = CMD_IGNORED;
          end
        end
      end
      default: ;
    endcase

    // Results past the per-character cap are dropped, but their effects stay.
    e_load      = e_req && (rc_q < RC_W'(RESULT_CAP));
    out_valid_d = out_valid_q && !m_tready_i;
    if (e_load) begin
      out_valid_d = 1'b1;
      rc_d        = rc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_load) begin
      out_cmd_q  <= e_cmd;
      out_off_q  <= e_off;
      out_word_q <= e_word;
      out_page_q <= e_page;
      out_err_q  <= e_err;
      out_last_q <= e_last || (rc_q == RC_W'(RESULT_CAP - 1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      job_q       <= '0;
      addr_q      <= 16'd0;
      pos_q       <= '0;
      prior_q     <= NO_ADDRESS;
      empty_q     <= 1'b1;
      halted_q    <= 1'b0;
      rc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      job_q       <= job_d;
      addr_q      <= addr_d;
      pos_q       <= pos_d;
      prior_q     <= prior_d;
      empty_q     <= empty_d;
      halted_q    <= halted_d;
      rc_q        <= rc_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = out_cmd_q;
  assign m_tdata_o  = {4'b0000, out_err_q, out_page_q, out_word_q, out_off_q};
  assign m_tlast_o  = out_last_q;

endmodule

`default_nettype wire

[rtl/hrfpl_checker.sv]
// Port-level checks of the loader's output stream, bound to the top level.
`default_nettype none

module hrfpl_checker (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire                              m_axis_tvalid,
  input wire                              m_axis_tready,
  input wire [hrfpl_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input wire [2:0]                        m_axis_tuser,
  input wire                              m_axis_tlast
);
  import hrfpl_pkg::*;

  // A stalled result transfer keeps its contents.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
      $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output transfer changed while stalled");

  // An error always carries a code and closes the run.
  a_error_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == CMD_ERROR) |->
      m_axis_tlast && (m_axis_tdata[43:41] != ERR_NONE))
    else $error("error result without code or last flag");

  a_code_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != CMD_ERROR) |-> m_axis_tdata[43:41] == ERR_NONE)
    else $error("error code on a non-error result");

  // The block halts after an error, so nothing follows it.
  a_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && (m_axis_tuser == CMD_ERROR) |=> !m_axis_tvalid)
    else $error("result after an error");

endmodule

bind hex_record_flash_page_loader hrfpl_checker u_hrfpl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
